// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when a holds, b holds too.
`define GKH_ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication: when a holds, b holds in the next cycle.
`define GKH_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/gkh_pkg.sv -----
// ----------------------------------------------------------------------------
// gkh_pkg
// Shared constants and types of the glyph key hash cache.
// ----------------------------------------------------------------------------
package gkh_pkg;

  localparam int unsigned TABLE_BITS  = 14;
  localparam int unsigned PROBE_LIMIT = 64;

  localparam int unsigned CP_W     = 21;
  localparam int unsigned STYLE_W  = 2;
  localparam int unsigned KEY_W    = CP_W + STYLE_W;
  localparam int unsigned SLOT_W   = 14;
  localparam int unsigned HASH_W   = 32;
  localparam logic [HASH_W-1:0] HASH_MULT = 32'd2654435761;

  // probe counter holds 0 .. PROBE_LIMIT-1
  localparam int unsigned PCNT_W = $clog2(PROBE_LIMIT + 1);

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_FLUSHED  = 2'd3
  } status_e;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic             valid;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic                  we;
    logic [TABLE_BITS-1:0] addr;
    entry_t                wdata;
  } mem_req_t;

endpackage

// ----- rtl/core/gkh_req_if.sv -----
// ----------------------------------------------------------------------------
// gkh_req_if
// Request channel: lookup or flush with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gkh_req_if import gkh_pkg::*; ();

  logic               valid;
  logic               ready;
  logic               req_type;
  logic [CP_W-1:0]    code_point;
  logic [STYLE_W-1:0] style;
  logic               render_ok;

  modport source (output valid, output req_type, output code_point, output style,
                  output render_ok, input ready);
  modport sink   (input valid, input req_type, input code_point, input style,
                  input render_ok, output ready);

endinterface

// ----- rtl/core/gkh_rsp_if.sv -----
// ----------------------------------------------------------------------------
// gkh_rsp_if
// Response channel: status, glyph flag and slot with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gkh_rsp_if import gkh_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic              glyph_ok;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, output status, output glyph_ok, output slot,
                  input ready);
  modport sink   (input valid, input status, input glyph_ok, input slot,
                  output ready);

endinterface

// ----- rtl/core/gkh_ram.sv -----
// ----------------------------------------------------------------------------
// gkh_ram
// Single-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module gkh_ram #(
  parameter int unsigned ADDR_W = 14,
  parameter int unsigned DATA_W = 25
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/gkh_hash.sv -----
// ----------------------------------------------------------------------------
// gkh_hash
// Multiplicative hash of the glyph key to its home slot.
// ----------------------------------------------------------------------------
module gkh_hash import gkh_pkg::*; (
  input  logic [KEY_W-1:0]      key_i,
  output logic [TABLE_BITS-1:0] home_o
);

  logic [HASH_W-1:0] prod;

  // product is taken modulo 2^32, the slot is its low bits
  assign prod   = {{(HASH_W-KEY_W){1'b0}}, key_i} * HASH_MULT;
  assign home_o = prod[TABLE_BITS-1:0];

endmodule

// ----- rtl/core/gkh_ctrl.sv -----
// ----------------------------------------------------------------------------
// gkh_ctrl
// Probe sequencer: clearing sweep, hash, linear probe, insert and response.
// ----------------------------------------------------------------------------
module gkh_ctrl import gkh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  gkh_req_if.sink    req_i,
  gkh_rsp_if.source  rsp_o,
  output mem_req_t   mem_req_o,
  input  entry_t     mem_rdata_i
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_HASH  = 4'b0100,
    S_PROBE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic                  flush_q, flush_d;
  logic [TABLE_BITS-1:0] clr_q, clr_d;
  logic [PCNT_W-1:0]     probe_q, probe_d;
  logic [TABLE_BITS-1:0] slot_q, slot_d;
  logic [KEY_W-1:0]      key_q, key_d;
  logic                  render_q, render_d;

  logic                  rsp_valid_q, rsp_valid_d;
  status_e               rsp_status_q, rsp_status_d;
  logic                  rsp_ok_q, rsp_ok_d;
  logic [SLOT_W-1:0]     rsp_slot_q, rsp_slot_d;

  logic [TABLE_BITS-1:0] home;
  logic                  out_free;
  logic                  hit, empty, last;

  gkh_hash u_hash (
    .key_i  (key_q),
    .home_o (home)
  );

  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign hit      = mem_rdata_i.used && (mem_rdata_i.key == key_q);
  assign empty    = !mem_rdata_i.used;
  assign last     = (probe_q == PCNT_W'(PROBE_LIMIT - 1));

  always_comb begin
    state_d      = state_q;
    flush_d      = flush_q;
    clr_d        = clr_q;
    probe_d      = probe_q;
    slot_d       = slot_q;
    key_d        = key_q;
    render_d     = render_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_ok_d     = rsp_ok_q;
    rsp_slot_d   = rsp_slot_q;

    req_i.ready           = 1'b0;
    mem_req_o.we          = 1'b0;
    mem_req_o.addr        = slot_q;
    mem_req_o.wdata.used  = 1'b1;
    mem_req_o.wdata.key   = key_q;
    mem_req_o.wdata.valid = render_q;

    case (state_q)
      S_CLEAR: begin
        mem_req_o.we         = 1'b1;
        mem_req_o.addr       = clr_q;
        mem_req_o.wdata.used = 1'b0;
        if (&clr_q) begin
          if (!flush_q) begin
            state_d = S_IDLE;
          end else if (out_free) begin
            rsp_valid_d  = 1'b1;
            rsp_status_d = ST_FLUSHED;
            rsp_ok_d     = 1'b0;
            rsp_slot_d   = '0;
            flush_d      = 1'b0;
            state_d      = S_IDLE;
          end
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          if (req_i.req_type == REQ_FLUSH) begin
            flush_d = 1'b1;
            clr_d   = '0;
            state_d = S_CLEAR;
          end else begin
            key_d    = {req_i.style, req_i.code_point};
            render_d = req_i.render_ok;
            state_d  = S_HASH;
          end
        end
      end

      S_HASH: begin
        mem_req_o.addr = home;
        slot_d         = home;
        probe_d        = '0;
        state_d        = S_PROBE;
      end

      S_PROBE: begin
        if (hit || empty || last) begin
          // hold the read on this slot until the response register frees up
          if (out_free) begin
            rsp_valid_d = 1'b1;
            state_d     = S_IDLE;
            if (hit) begin
              rsp_status_d = ST_HIT;
              rsp_ok_d     = mem_rdata_i.valid;
              rsp_slot_d   = SLOT_W'(slot_q);
            end else if (empty) begin
              mem_req_o.we = 1'b1;
              rsp_status_d = ST_INSERTED;
              rsp_ok_d     = render_q;
              rsp_slot_d   = SLOT_W'(slot_q);
            end else begin
              rsp_status_d = ST_FULL;
              rsp_ok_d     = 1'b0;
              rsp_slot_d   = '0;
            end
          end
        end else begin
          // advance to the next slot, wrapping at the table end
          mem_req_o.addr = slot_q + 1'b1;
          slot_d         = slot_q + 1'b1;
          probe_d        = probe_q + 1'b1;
        end
      end

      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      flush_q     <= 1'b0;
      clr_q       <= '0;
      probe_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      flush_q     <= flush_d;
      clr_q       <= clr_d;
      probe_q     <= probe_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q       <= slot_d;
    key_q        <= key_d;
    render_q     <= render_d;
    rsp_status_q <= rsp_status_d;
    rsp_ok_q     <= rsp_ok_d;
    rsp_slot_q   <= rsp_slot_d;
  end

  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.status   = rsp_status_q;
  assign rsp_o.glyph_ok = rsp_ok_q;
  assign rsp_o.slot     = rsp_slot_q;

endmodule

// ----- rtl/core/glyph_key_hash_cache.sv -----
// Lookup: the key is registered, its home slot read, and each extra probe reads the next slot.
// Lookups: one in work at a time over the single RAM port, which reads one slot a cycle.
// Flush: one entry a cycle cleared via the RAM port; the last waits for a free response register.
// Reset: asynchronous, active low; a pass clearing 2^TABLE_BITS entries follows, no request taken.
// The response register lets a new request in while a result waits to be taken.
// ----------------------------------------------------------------------------
// glyph_key_hash_cache
// Glyph cache tag engine: linear-probing hash table over one single-port RAM.
// ----------------------------------------------------------------------------
module glyph_key_hash_cache import gkh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  gkh_req_if.sink   req_i,
  gkh_rsp_if.source rsp_o
);

  mem_req_t          mem_req;
  logic [ENTRY_W-1:0] mem_rdata;

  gkh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (entry_t'(mem_rdata))
  );

  gkh_ram #(
    .ADDR_W (TABLE_BITS),
    .DATA_W (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

endmodule

// ----- rtl/core/gkh_checker.sv -----
// ----------------------------------------------------------------------------
// gkh_checker
// Port-level checks of the glyph key hash cache, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gkh_checker import gkh_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [1:0]        rsp_status_i,
  input logic              rsp_glyph_ok_i,
  input logic [SLOT_W-1:0] rsp_slot_i
);

  logic [SLOT_W+2:0] rsp_fields;
  logic              rsp_stall;
  logic              rsp_flush;
  logic              rsp_full;
  logic              rsp_blank;

  assign rsp_fields = {rsp_status_i, rsp_glyph_ok_i, rsp_slot_i};
  assign rsp_stall  = rsp_valid_i && !rsp_ready_i;
  assign rsp_flush  = rsp_valid_i && (rsp_status_i == ST_FLUSHED);
  assign rsp_full   = rsp_valid_i && (rsp_status_i == ST_FULL);
  assign rsp_blank  = !rsp_glyph_ok_i && (rsp_slot_i == '0);

  // a stalled response keeps its payload
  `GKH_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_stall, rsp_valid_i && $stable(rsp_fields))

  // one request in work at a time
  `GKH_ASSERT_NEXT(a_one_busy, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)

  `GKH_ASSERT_IMPLY(a_flush_fields, clk_i, rst_ni, rsp_flush, rsp_blank)

  `GKH_ASSERT_IMPLY(a_full_fields, clk_i, rst_ni, rsp_full, rsp_blank)

endmodule

bind glyph_key_hash_cache gkh_checker u_gkh_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_status_i   (rsp_o.status),
  .rsp_glyph_ok_i (rsp_o.glyph_ok),
  .rsp_slot_i     (rsp_o.slot)
);
